// ===== rtl/time_of_day_add_sub_compare_unit_assert.svh =====
// Assertion macros for the time-of-day unit RTL.
`ifndef TIME_OF_DAY_ADD_SUB_COMPARE_UNIT_ASSERT_SVH
`define TIME_OF_DAY_ADD_SUB_COMPARE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TDASC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("time-of-day unit assertion failed");
`define TDASC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("time-of-day unit assertion failed");
`else
`define TDASC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TDASC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tdasc_pkg.sv =====
// Types, constants and digit helpers for the time-of-day unit.
package tdasc_pkg;

	localparam logic [9:0] MS_RADIX   = 10'd1000;
	localparam logic [9:0] SEC_RADIX  = 10'd60;
	localparam logic [9:0] MIN_RADIX  = 10'd60;
	localparam logic [9:0] HOUR_RADIX = 10'd24;
	localparam logic [4:0] HALF_HOUR  = 5'd12;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_CMP = 2'd2,
		CMD_RSV = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] a_hour;
		logic [5:0] a_min;
		logic [5:0] a_sec;
		logic [9:0] a_msec;
		logic [4:0] b_hour;
		logic [5:0] b_min;
		logic [5:0] b_sec;
		logic [9:0] b_msec;
	} op_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] r_hour;
		logic [5:0] r_min;
		logic [5:0] r_sec;
		logic [9:0] r_msec;
		logic       later;
	} res_t;

	// One mixed-radix digit of a sum: returns {carry, digit}.
	function automatic logic [10:0] dig_add(input logic [9:0] x, input logic [9:0] y,
		input logic ci, input logic [9:0] radix);
		logic [10:0] sum;
		logic [10:0] res;
		sum = {1'b0, x} + {1'b0, y} + {10'd0, ci};
		if (sum >= {1'b0, radix}) begin
			res = {1'b1, 10'(sum - {1'b0, radix})};
		end else begin
			res = {1'b0, sum[9:0]};
		end
		return res;
	endfunction

	// One mixed-radix digit of a difference: returns {borrow, digit}.
	function automatic logic [10:0] dig_sub(input logic [9:0] x, input logic [9:0] y,
		input logic bi, input logic [9:0] radix);
		logic [10:0] diff;
		logic [10:0] res;
		diff = {1'b0, x} - {1'b0, y} - {10'd0, bi};
		if (diff[10]) begin
			res = {1'b1, 10'(diff + {1'b0, radix})};
		end else begin
			res = {1'b0, diff[9:0]};
		end
		return res;
	endfunction

endpackage

// ===== rtl/tdasc_core.sv =====
// Range check, digit-wise add and subtract, and half-day compare.
module tdasc_core (
	input  tdasc_pkg::op_t  op,
	output tdasc_pkg::res_t res
);

	logic        a_ok, b_ok;
	logic [10:0] ad_ms, ad_s, ad_m, ad_h;
	logic [10:0] sb_ms, sb_s, sb_m, sb_h;
	logic [10:0] cd_ms, cd_s, cd_m, cd_h;
	logic        d_zero, d_below, d_half, cmp_later;

	assign a_ok = (op.a_hour < 5'd24) && (op.a_min < 6'd60) && (op.a_sec < 6'd60)
		&& (op.a_msec < 10'd1000);
	assign b_ok = (op.b_hour < 5'd24) && (op.b_min < 6'd60) && (op.b_sec < 6'd60)
		&& (op.b_msec < 10'd1000);

	// Add: carries ripple from milliseconds up; the final carry is the day wrap.
	assign ad_ms = tdasc_pkg::dig_add(op.a_msec, op.b_msec, 1'b0, tdasc_pkg::MS_RADIX);
	assign ad_s  = tdasc_pkg::dig_add({4'd0, op.a_sec}, {4'd0, op.b_sec}, ad_ms[10],
		tdasc_pkg::SEC_RADIX);
	assign ad_m  = tdasc_pkg::dig_add({4'd0, op.a_min}, {4'd0, op.b_min}, ad_s[10],
		tdasc_pkg::MIN_RADIX);
	assign ad_h  = tdasc_pkg::dig_add({5'd0, op.a_hour}, {5'd0, op.b_hour}, ad_m[10],
		tdasc_pkg::HOUR_RADIX);

	// Subtract a minus b; a borrow out of the hour digit adds one day.
	assign sb_ms = tdasc_pkg::dig_sub(op.a_msec, op.b_msec, 1'b0, tdasc_pkg::MS_RADIX);
	assign sb_s  = tdasc_pkg::dig_sub({4'd0, op.a_sec}, {4'd0, op.b_sec}, sb_ms[10],
		tdasc_pkg::SEC_RADIX);
	assign sb_m  = tdasc_pkg::dig_sub({4'd0, op.a_min}, {4'd0, op.b_min}, sb_s[10],
		tdasc_pkg::MIN_RADIX);
	assign sb_h  = tdasc_pkg::dig_sub({5'd0, op.a_hour}, {5'd0, op.b_hour}, sb_m[10],
		tdasc_pkg::HOUR_RADIX);

	// Compare works on how far b lies ahead of a, modulo one day.
	assign cd_ms = tdasc_pkg::dig_sub(op.b_msec, op.a_msec, 1'b0, tdasc_pkg::MS_RADIX);
	assign cd_s  = tdasc_pkg::dig_sub({4'd0, op.b_sec}, {4'd0, op.a_sec}, cd_ms[10],
		tdasc_pkg::SEC_RADIX);
	assign cd_m  = tdasc_pkg::dig_sub({4'd0, op.b_min}, {4'd0, op.a_min}, cd_s[10],
		tdasc_pkg::MIN_RADIX);
	assign cd_h  = tdasc_pkg::dig_sub({5'd0, op.b_hour}, {5'd0, op.a_hour}, cd_m[10],
		tdasc_pkg::HOUR_RADIX);

	assign d_zero  = (cd_h[4:0] == 5'd0) && (cd_m[5:0] == 6'd0) && (cd_s[5:0] == 6'd0)
		&& (cd_ms[9:0] == 10'd0);
	assign d_below = cd_h[4:0] < tdasc_pkg::HALF_HOUR;
	assign d_half  = (cd_h[4:0] == tdasc_pkg::HALF_HOUR) && (cd_m[5:0] == 6'd0)
		&& (cd_s[5:0] == 6'd0) && (cd_ms[9:0] == 10'd0);
	// At exactly half a day apart, b is ahead only when it sits in the afternoon.
	assign cmp_later = !d_zero && (d_below || (d_half && (op.b_hour >= tdasc_pkg::HALF_HOUR)));

	always_comb begin
		res = '0;
		if (a_ok && b_ok) begin
			res.ok = 1'b1;
			case (tdasc_pkg::cmd_t'(op.cmd))
				tdasc_pkg::CMD_ADD: begin
					res.r_hour = ad_h[4:0];
					res.r_min  = ad_m[5:0];
					res.r_sec  = ad_s[5:0];
					res.r_msec = ad_ms[9:0];
				end
				tdasc_pkg::CMD_SUB: begin
					res.r_hour = sb_h[4:0];
					res.r_min  = sb_m[5:0];
					res.r_sec  = sb_s[5:0];
					res.r_msec = sb_ms[9:0];
				end
				tdasc_pkg::CMD_CMP: begin
					res.later = cmp_later;
				end
				default: begin
					res.later = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/time_of_day_add_sub_compare_unit.sv =====
// Top level of the time-of-day add, subtract and compare unit.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   cmd, a_hour..a_msec, b_hour..b_msec
//   result    out        out_valid / out_stall ok, r_hour, r_min, r_sec, r_msec, later
//
// A transaction passes an input register and a result register. One transaction is
// accepted per cycle unless in_stall; the throughput limit is the result register.
// Reset clears both valid flags; payload registers are not reset.
// While the result waits under out_stall, one more transaction is still taken into the
// input register; in_stall rises only when both registers hold work.
`include "time_of_day_add_sub_compare_unit_assert.svh"
module time_of_day_add_sub_compare_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [4:0] a_hour,
	input  logic [5:0] a_min,
	input  logic [5:0] a_sec,
	input  logic [9:0] a_msec,
	input  logic [4:0] b_hour,
	input  logic [5:0] b_min,
	input  logic [5:0] b_sec,
	input  logic [9:0] b_msec,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       ok,
	output logic [4:0] r_hour,
	output logic [5:0] r_min,
	output logic [5:0] r_sec,
	output logic [9:0] r_msec,
	output logic       later
);

	logic            valid_s1, valid_s2;
	logic            load_s1, load_s2;
	tdasc_pkg::op_t  op_s1;
	tdasc_pkg::res_t res_comb, res_s2;
	logic            r_zero, r_in_range;

	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1 || load_s2) begin
				valid_s1 <= load_s1;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1 <= '{cmd: cmd, a_hour: a_hour, a_min: a_min, a_sec: a_sec, a_msec: a_msec,
				b_hour: b_hour, b_min: b_min, b_sec: b_sec, b_msec: b_msec};
		end
		if (load_s2) begin
			res_s2 <= res_comb;
		end
	end

	tdasc_core u_core (
		.op  (op_s1),
		.res (res_comb)
	);

	assign out_valid = valid_s2;
	assign ok        = res_s2.ok;
	assign r_hour    = res_s2.r_hour;
	assign r_min     = res_s2.r_min;
	assign r_sec     = res_s2.r_sec;
	assign r_msec    = res_s2.r_msec;
	assign later     = res_s2.later;

	assign r_zero     = (r_hour == 5'd0) && (r_min == 6'd0) && (r_sec == 6'd0)
		&& (r_msec == 10'd0);
	assign r_in_range = (r_hour < 5'd24) && (r_min < 6'd60) && (r_sec < 6'd60)
		&& (r_msec < 10'd1000);

	`TDASC_ASSERT_SAME(a_bad_zero, clk, arst_n, valid_s2 && !ok, r_zero && !later)
	`TDASC_ASSERT_SAME(a_range, clk, arst_n, valid_s2, r_in_range)
	`TDASC_ASSERT_SAME(a_later_cmp, clk, arst_n, valid_s2 && later, ok && r_zero)
	`TDASC_ASSERT_SAME(a_full_stall, clk, arst_n, valid_s1 && valid_s2 && out_stall, in_stall)
	`TDASC_ASSERT_NEXT(a_s1_moves, clk, arst_n, valid_s1 && !valid_s2, valid_s2)

endmodule
